// ===== hdl/sha256_byte_stream_hasher_macros.svh =====
// assertion macros shared by the hasher rtl
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

// clocked check, off while reset is applied
`define SBH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define SBH_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/sha256_pkg.sv =====
// sha-256 round constants, initial hash values and sigma functions
package sha256_pkg;

    localparam int unsigned WordW = 32;

    // padding marker byte and the byte offset where the length field starts
    localparam logic [7:0] PadMark = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

    localparam logic [WordW-1:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [WordW-1:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

// ===== hdl/sha256_byte_stream_hasher.sv =====
// sha-256 byte stream hasher: byte buffer, schedule window, round engine, digest out
// Message bytes are taken only while idle; each completed 64-byte block stalls the
// input through the window load, the rounds and the chain update. An end item pads
// one byte per cycle through the same byte path (up to 72 bytes), pausing while
// each filled block is compressed; then eight digest words follow, each held until
// the sink accepts it. The single round engine and the chain memory bound block rate.
// Synchronous active-low reset returns to the initial hash values, no result pending.
`include "sha256_byte_stream_hasher_macros.svh"

module sha256_byte_stream_hasher
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_FIN,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_HOLD
    } t_state;

    localparam logic [5:0] LoadEnd  = 6'd16;
    localparam logic [5:0] RoundEnd = 6'd63;
    localparam logic [5:0] FinEnd   = 6'd8;

    t_state      r_state;
    logic [5:0]  r_fill;
    logic [63:0] r_total_bits;
    logic [5:0]  r_cnt;
    logic [3:0]  r_rd_idx;
    logic        r_rd_vld;
    logic        r_chain_init;
    logic        r_pad_mode;
    logic        r_pad_first;
    logic        r_len_ok;
    logic        r_final;
    logic [2:0]  r_oidx;
    logic        r_out_vld;
    logic [31:0] r_out_word;
    logic [2:0]  r_out_idx;
    logic        r_out_last;

    logic [23:0] r_acc;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];

    // block word memory and chain value memory
    logic [31:0] word_mem  [16];
    logic [31:0] chain_mem [8];
    logic [31:0] r_word_q;
    logic [31:0] r_chain_q;

    logic        in_acc;
    logic        absorb;
    logic [7:0]  abs_byte;
    logic [7:0]  pad_byte;
    logic [63:0] len_shift;
    logic [31:0] chain_rd;
    logic [31:0] chain_sum;
    logic        chain_we;
    logic [2:0]  chain_raddr;
    logic [31:0] w_next;
    logic [31:0] t1;
    logic [31:0] t2;
    logic        out_acc;

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_vld;
    assign o_digest_word = r_out_word;
    assign o_word_index  = r_out_idx;
    assign o_last_word   = r_out_last;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_out_vld && !i_stall;

    // byte source: message byte or generated padding
    assign len_shift = r_total_bits >> {~r_fill[2:0], 3'b000};
    always_comb begin
        if (r_pad_first) begin
            pad_byte = PadMark;
        end else if (r_len_ok && (r_fill >= LenPos)) begin
            pad_byte = len_shift[7:0];
        end else begin
            pad_byte = 8'h00;
        end
    end
    assign absorb   = (in_acc && i_byte_present) || (r_state == S_PAD);
    assign abs_byte = (r_state == S_PAD) ? pad_byte : i_data_byte;

    // chain update read-modify-write
    assign chain_rd    = r_chain_init ? InitHash[r_rd_idx[2:0]] : r_chain_q;
    assign chain_sum   = chain_rd + r_v[r_rd_idx[2:0]];
    assign chain_we    = (r_state == S_FIN) && r_rd_vld;
    assign chain_raddr = (r_state == S_OUT_RD) ? r_oidx : r_cnt[2:0];

    // schedule expansion and round function
    assign w_next = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
    assign t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + RoundK[r_cnt] + r_w[0];
    assign t2 = big_sigma0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // memories
    always_ff @(posedge i_clk) begin
        if (absorb && (r_fill[1:0] == 2'b11)) begin
            word_mem[r_fill[5:2]] <= {r_acc, abs_byte};
        end
        r_word_q <= word_mem[r_cnt[3:0]];
        if (chain_we) begin
            chain_mem[r_rd_idx[2:0]] <= chain_sum;
        end
        r_chain_q <= chain_mem[chain_raddr];
    end

    // byte packing, schedule window and working variables
    always_ff @(posedge i_clk) begin
        if (absorb) begin
            r_acc <= {r_acc[15:0], abs_byte};
        end
        case (r_state)
            S_LOAD: begin
                if (r_rd_vld) begin
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[15] <= r_word_q;
                    if (!r_rd_idx[3]) begin
                        r_v[r_rd_idx[2:0]] <= chain_rd;
                    end
                end
            end
            S_ROUND: begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i+1];
                end
                r_w[15] <= w_next;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
            end
            default: begin
            end
        endcase
    end

    // control state machine and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_total_bits <= '0;
            r_cnt        <= '0;
            r_rd_idx     <= '0;
            r_rd_vld     <= 1'b0;
            r_chain_init <= 1'b1;
            r_pad_mode   <= 1'b0;
            r_pad_first  <= 1'b0;
            r_len_ok     <= 1'b0;
            r_final      <= 1'b0;
            r_oidx       <= '0;
            r_out_vld    <= 1'b0;
            r_out_idx    <= '0;
            r_out_last   <= 1'b0;
        end else begin
            r_rd_vld <= ((r_state == S_LOAD) && (r_cnt < LoadEnd))
                     || ((r_state == S_FIN) && (r_cnt < FinEnd));
            r_rd_idx <= r_cnt[3:0];
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_end_of_message) begin
                            r_pad_mode  <= 1'b1;
                            r_pad_first <= 1'b1;
                            r_state     <= S_PAD;
                        end
                        if (i_byte_present) begin
                            r_fill       <= r_fill + 6'd1;
                            r_total_bits <= r_total_bits + 64'd8;
                            if (r_fill == 6'd63) begin
                                r_state <= S_LOAD;
                                r_cnt   <= '0;
                                r_final <= 1'b0;
                            end
                        end
                    end
                end
                S_PAD: begin
                    r_pad_first <= 1'b0;
                    if (r_pad_first) begin
                        r_len_ok <= (r_fill < LenPos);
                    end
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == 6'd63) begin
                        r_state  <= S_LOAD;
                        r_cnt    <= '0;
                        r_final  <= !r_pad_first && r_len_ok;
                        r_len_ok <= 1'b1;
                    end
                end
                S_LOAD: begin
                    if (r_cnt == LoadEnd) begin
                        r_state <= S_ROUND;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_ROUND: begin
                    if (r_cnt == RoundEnd) begin
                        r_state <= S_FIN;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_FIN: begin
                    if (r_cnt == FinEnd) begin
                        r_chain_init <= 1'b0;
                        r_cnt        <= '0;
                        if (r_final) begin
                            r_state    <= S_OUT_RD;
                            r_oidx     <= '0;
                            r_pad_mode <= 1'b0;
                        end else if (r_pad_mode) begin
                            r_state <= S_PAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_OUT_RD: begin
                    r_state <= S_OUT_LD;
                end
                S_OUT_LD: begin
                    r_out_word <= r_chain_q;
                    r_out_idx  <= r_oidx;
                    r_out_last <= (r_oidx == 3'd7);
                    r_out_vld  <= 1'b1;
                    r_state    <= S_OUT_HOLD;
                end
                S_OUT_HOLD: begin
                    if (out_acc) begin
                        r_out_vld <= 1'b0;
                        if (r_oidx == 3'd7) begin
                            r_state      <= S_IDLE;
                            r_chain_init <= 1'b1;
                            r_fill       <= '0;
                            r_total_bits <= '0;
                        end else begin
                            r_oidx  <= r_oidx + 3'd1;
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output valid is high exactly while the digest word is held for the sink
    `SBH_ASSERT(a_out_vld_state, (o_valid == (r_state == S_OUT_HOLD)), "output valid outside digest hold")
    // a digest word never comes from the initial hash values
    `SBH_ASSERT(a_out_from_mem, (o_valid |-> !r_chain_init), "digest read before chain update")
    // the last word closes the message and restarts the chain
    `SBH_ASSERT(a_msg_restart, (out_acc && o_last_word |=> r_chain_init && r_total_bits == 64'd0 && r_fill == 6'd0), "message state not restarted after digest")
    // the round counter hands over to the chain update after the last round
    `SBH_ASSERT(a_round_done, (r_state == S_ROUND && r_cnt == RoundEnd |=> r_state == S_FIN), "round sequence not closed")
    // a full block always starts compression with an empty fill
    `SBH_ASSERT(a_block_fill, (r_state == S_LOAD |-> r_fill == 6'd0), "compression started on a partial block")

endmodule
